>>> src/b64e_pkg.sv
// b64e_pkg: shared types, constants and the sextet-to-ASCII mapping for the
// streaming Base64 encoder. No dependencies.
`default_nettype none

package b64e_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] PAD_FINAL = 8'h3D;  // '='
   localparam logic [7:0] PAD_JOIN  = 8'h41;  // 'A'

   // One classified input byte: up to four characters ready to go out
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [1:0]      last_idx;
      logic            text_last;
   } job_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] s);
      logic [7:0] v;
      begin
         v = {2'b00, s};
         if (s < 6'd26) begin
            return 8'h41 + v;                // 'A'..'Z'
         end else if (s < 6'd52) begin
            return 8'h61 + (v - 8'd26);      // 'a'..'z'
         end else if (s < 6'd62) begin
            return 8'h30 + (v - 8'd52);      // '0'..'9'
         end else if (s == 6'd62) begin
            return 8'h2B;                    // '+'
         end else begin
            return 8'h2F;                    // '/'
         end
      end
   endfunction

endpackage

`default_nettype wire

>>> src/b64e_front.sv
// b64e_front: takes input bytes, tracks the position in the 3-byte group and
// the leftover bits, and builds one job of characters per byte. Uses b64e_pkg.
`default_nettype none

module b64e_front
   import b64e_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       take,
   input  wire logic [7:0] in_byte,
   input  wire logic       last_byte,
   input  wire logic       final_chunk,
   output job_type         job
);

   logic [1:0] group_pos_ff, group_pos_in;
   logic [3:0] held_ff, held_in;
   logic [7:0] pad;

   always_comb begin
      pad          = final_chunk ? PAD_FINAL : PAD_JOIN;
      job.chars    = {4{pad}};
      job.last_idx = 2'd0;
      job.text_last = last_byte;
      group_pos_in = group_pos_ff;
      held_in      = held_ff;
      case (group_pos_ff)
         2'd1: begin
            job.chars[0] = sextet_char({held_ff[1:0], in_byte[7:4]});
            group_pos_in = 2'd2;
            held_in      = in_byte[3:0];
            if (last_byte) begin
               job.chars[1] = sextet_char({in_byte[3:0], 2'b00});
               job.last_idx = 2'd2;
            end
         end
         2'd2: begin
            job.chars[0] = sextet_char({held_ff, in_byte[7:6]});
            job.chars[1] = sextet_char(in_byte[5:0]);
            job.last_idx = 2'd1;
            group_pos_in = 2'd0;
            held_in      = 4'd0;
         end
         default: begin
            job.chars[0] = sextet_char(in_byte[7:2]);
            group_pos_in = 2'd1;
            held_in      = {2'b00, in_byte[1:0]};
            if (last_byte) begin
               job.chars[1] = sextet_char({in_byte[1:0], 4'b0000});
               job.last_idx = 2'd3;
            end
         end
      endcase
      // flush returns the group to its start
      if (last_byte) begin
         group_pos_in = 2'd0;
         held_in      = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_pos_ff <= 2'd0;
         held_ff      <= 4'd0;
      end else if (take) begin
         group_pos_ff <= group_pos_in;
         held_ff      <= held_in;
      end
   end

endmodule

`default_nettype wire

>>> src/b64e_queue.sv
// b64e_queue: short register queue of jobs between front and back.
// Uses b64e_pkg for the job type.
`default_nettype none

module b64e_queue
   import b64e_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_en,
   input  wire job_type wr_job,
   output logic         full,
   input  wire logic    rd_en,
   output job_type      rd_job,
   output logic         rd_valid
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_wr, do_rd;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_job   = entries_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

>>> src/b64e_back.sv
// b64e_back: walks the characters of the head job into the output register,
// one per cycle while it is empty or popped. Uses b64e_pkg for the job type.
`default_nettype none

module b64e_back
   import b64e_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire job_type    job,
   input  wire logic       job_valid,
   output logic            job_done,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_run_last,
   output logic            rsp_text_last
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff;
   logic       run_last_ff, text_last_ff;
   logic       load, at_end;

   assign load     = job_valid && (!valid_ff || rsp_pop);
   assign at_end   = (idx_ff == job.last_idx);
   assign job_done = load && at_end;
   assign idx_in   = at_end ? 2'd0 : idx_ff + 2'd1;
   assign valid_in = load ? 1'b1 : (rsp_pop ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            idx_ff <= idx_in;
         end
      end
   end

   // payload of the output register
   always_ff @(posedge clock) begin
      if (load) begin
         char_ff      <= job.chars[idx_ff];
         run_last_ff  <= at_end;
         text_last_ff <= at_end && job.text_last;
      end
   end

   assign rsp_empty     = !valid_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_run_last  = run_last_ff;
   assign rsp_text_last = text_last_ff;

endmodule

`default_nettype wire

>>> src/base64_encoder_stream_unit.sv
// Streaming Base64 encoder: one byte in per transfer, ASCII characters out.
// A byte's characters pass through the job queue and then the output stage.
// Throughput: one character per cycle from the output stage while the receiver
// pops; a byte yields 1 to 4 characters, a full group of 3 bytes yields 4.
// Reset (synchronous, active high) empties the job queue and output stage and
// returns the group position to the start of a group.
`default_nettype none

module base64_encoder_stream_unit
   import b64e_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_last_byte,
   input  wire logic       req_final_chunk,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_run_last,
   output logic            rsp_text_last
);

   job_type new_job, head_job;
   logic    take, head_valid, head_done;

   assign take = req_push && !req_full;

   b64e_front u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .in_byte     (req_in_byte),
      .last_byte   (req_last_byte),
      .final_chunk (req_final_chunk),
      .job         (new_job)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (take),
      .wr_job   (new_job),
      .full     (req_full),
      .rd_en    (head_done),
      .rd_job   (head_job),
      .rd_valid (head_valid)
   );

   b64e_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job           (head_job),
      .job_valid     (head_valid),
      .job_done      (head_done),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_char  (rsp_out_char),
      .rsp_run_last  (rsp_run_last),
      .rsp_text_last (rsp_text_last)
   );

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for base64_encoder_stream_unit. Feeds raw bytes
// and checks every emitted character against a local encoder model.
// Depends on b64e_pkg (pad codes) and the encoder RTL.

module testbench;
   import b64e_pkg::*;

   localparam int NUM_RANDOM   = 450;
   localparam int STALL_LIMIT  = 2000;   // cycles with no transfer on either side
   localparam int HOLD_CYCLES  = 150;    // long receiver hold-off to back up the input
   localparam int HOLD_SPACING = 500;
   localparam int DRAIN_CYCLES = 12;
   localparam string ALPHABET  =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       fin;
   } raw_byte_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       run_last;
      logic       text_last;
   } b64_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       req_final_chunk = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_run_last;
   logic       rsp_text_last;

   raw_byte_type  pending_bytes[$];
   b64_char_type  chars_due[$];
   b64_char_type  want;

   // encoder state: place in the 3-byte group and bits not yet emitted
   logic [1:0] grp_pos = 2'd0;
   logic [3:0] carry_bits = 4'd0;

   int errors = 0;
   int chars_checked = 0;
   int idle_cycles = 0;
   bit push_done = 1'b0;
   bit pop_done = 1'b0;
   int send_gap = 0;
   int send_calm = 0;
   int recv_stall = 0;
   int recv_calm = 0;
   int hold_left = 0;
   int next_hold_at = 60;

   base64_encoder_stream_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_in_byte     (req_in_byte),
      .req_last_byte   (req_last_byte),
      .req_final_chunk (req_final_chunk),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_char    (rsp_out_char),
      .rsp_run_last    (rsp_run_last),
      .rsp_text_last   (rsp_text_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic log_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
   endtask

   function automatic logic [7:0] sextet_ascii(input logic [5:0] s);
      return ALPHABET[s];
   endfunction

   // Advances the group state by one byte and queues the characters it yields.
   function automatic void encode_byte(input logic [7:0] b, input logic last,
                                       input logic fin);
      logic [7:0] out [4];
      logic [7:0] pad;
      int n;
      b64_char_type c;
      pad = fin ? PAD_FINAL : PAD_JOIN;
      n = 0;
      case (grp_pos)
         2'd1: begin
            out[0] = sextet_ascii({carry_bits[1:0], b[7:4]});
            carry_bits = b[3:0];
            grp_pos = 2'd2;
            n = 1;
            if (last) begin
               out[1] = sextet_ascii({b[3:0], 2'b00});
               out[2] = pad;
               n = 3;
            end
         end
         2'd2: begin
            out[0] = sextet_ascii({carry_bits, b[7:6]});
            out[1] = sextet_ascii(b[5:0]);
            carry_bits = 4'd0;
            grp_pos = 2'd0;
            n = 2;
         end
         default: begin
            out[0] = sextet_ascii(b[7:2]);
            carry_bits = {2'b00, b[1:0]};
            grp_pos = 2'd1;
            n = 1;
            if (last) begin
               out[1] = sextet_ascii({b[1:0], 4'b0000});
               out[2] = pad;
               out[3] = pad;
               n = 4;
            end
         end
      endcase
      if (last) begin
         grp_pos = 2'd0;
         carry_bits = 4'd0;
      end
      for (int i = 0; i < n; i++) begin
         c = '{ch: out[i], run_last: (i == n - 1), text_last: (last && (i == n - 1))};
         chars_due = {chars_due, c};
      end
   endfunction

   // Mostly short gaps, a few long ones, now and then a stretch with none.
   function automatic int next_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic add_byte(input logic [7:0] data, input logic last, input logic fin);
      raw_byte_type rb;
      rb = '{data: data, last: last, fin: fin};
      pending_bytes = {pending_bytes, rb};
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!(req_push && !push_done)) begin
         if (push_done) send_gap = next_gap(send_calm);
         if (send_gap > 0 || pending_bytes.size() == 0) begin
            if (send_gap > 0) send_gap--;
            req_push <= 1'b0;
         end else begin
            req_push        <= 1'b1;
            req_in_byte     <= pending_bytes[0].data;
            req_last_byte   <= pending_bytes[0].last;
            req_final_chunk <= pending_bytes[0].fin;
         end
      end
   end

   // receiver: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (chars_checked >= next_hold_at) begin
            hold_left = HOLD_CYCLES;
            next_hold_at += HOLD_SPACING;
         end
         if (pop_done) recv_stall = next_gap(recv_calm);
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // monitor: prediction on input transfers, checking on output transfers
   always @(posedge clock) begin
      push_done = !reset && req_push && !req_full;
      pop_done  = !reset && rsp_pop && !rsp_empty;
      if (reset) begin
         grp_pos = 2'd0;
         carry_bits = 4'd0;
         idle_cycles = 0;
      end else begin
         if (push_done) begin
            encode_byte(req_in_byte, req_last_byte, req_final_chunk);
            pending_bytes.delete(0);
         end
         if (pop_done) begin
            if (chars_due.size() == 0) begin
               log_error($sformatf("unexpected char 0x%02h run_last=%0b text_last=%0b",
                                   rsp_out_char, rsp_run_last, rsp_text_last));
            end else begin
               want = chars_due.pop_front();
               chars_checked++;
               if (rsp_out_char !== want.ch)
                  log_error($sformatf("char #%0d out_char 0x%02h, want 0x%02h",
                                      chars_checked, rsp_out_char, want.ch));
               if (rsp_run_last !== want.run_last)
                  log_error($sformatf("char #%0d run_last %0b, want %0b",
                                      chars_checked, rsp_run_last, want.run_last));
               if (rsp_text_last !== want.text_last)
                  log_error($sformatf("char #%0d text_last %0b, want %0b",
                                      chars_checked, rsp_text_last, want.text_last));
            end
         end
         if (push_done || pop_done) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("ERROR @%0t: no transfer for %0d cycles, %0d bytes pending, %0d chars due",
                        $time, idle_cycles, pending_bytes.size(), chars_due.size());
               $display("TEST FAILED");
               $finish;
            end
         end
      end
   end

   initial begin
      int len;
      int num_random;
      logic last;
      logic fin;

      // flush from each group position, both pad kinds
      add_byte(8'h00, 1'b1, 1'b1);
      add_byte(8'hFF, 1'b1, 1'b0);
      add_byte(8'hFF, 1'b0, 1'b0);
      add_byte(8'h00, 1'b1, 1'b1);
      add_byte(8'hA5, 1'b0, 1'b0);
      add_byte(8'h5A, 1'b1, 1'b0);
      add_byte(8'hFF, 1'b0, 1'b0);
      add_byte(8'hFF, 1'b0, 1'b0);
      add_byte(8'hFF, 1'b1, 1'b1);
      // final_chunk without last_byte has no effect
      add_byte(8'h00, 1'b0, 1'b1);
      add_byte(8'h80, 1'b0, 1'b1);
      add_byte(8'h7F, 1'b1, 1'b0);
      // '+' in every sextet of a full group, then joined chunks without a flush
      add_byte(8'hFB, 1'b0, 1'b0);
      add_byte(8'hEF, 1'b0, 1'b0);
      add_byte(8'hBE, 1'b0, 1'b0);
      add_byte(8'h55, 1'b0, 1'b0);
      add_byte(8'hAA, 1'b0, 1'b1);
      add_byte(8'h01, 1'b1, 1'b1);
      add_byte(8'h3E, 1'b1, 1'b0);

      num_random = 0;
      while (num_random < NUM_RANDOM) begin
         len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 24);
         for (int i = 0; i < len; i++) begin
            // a buffer now and then runs on into the next one without a flush
            last = (i == len - 1) && ($urandom_range(0, 9) != 0);
            fin  = last ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 3) == 0);
            add_byte(8'($urandom_range(0, 255)), last, fin);
            num_random++;
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || chars_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_queue.sv
src/b64e_back.sv
src/base64_encoder_stream_unit.sv
sim/testbench.sv
